// ----- design/tcfcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfcd_pkg
// Shared types and constants of the timed color fade engine.
// ----------------------------------------------------------------------------
package tcfcd_pkg;

  localparam int NUM_COLORS_DEF = 8;
  localparam int SPS_DEF        = 50;
  localparam int HOURS          = 24;
  localparam int QDEPTH         = 2;   // front-to-back queue
  localparam int ODEPTH         = 2;   // result queue

  localparam logic [1:0]  CMD_TICK  = 2'd0;
  localparam logic [1:0]  CMD_COLOR = 2'd1;
  localparam logic [1:0]  CMD_MAP   = 2'd2;

  localparam logic [1:0]  REG_RAMP   = 2'd0;
  localparam logic [1:0]  REG_FIXED  = 2'd1;
  localparam logic [1:0]  REG_CLOUDS = 2'd2;

  localparam logic [4:0]  HOUR_NONE  = 5'd24;
  localparam logic [4:0]  HOUR_LAST  = 5'd23;
  localparam logic [6:0]  DENS_MAX   = 7'd100;
  localparam logic [16:0] DIM_ONE    = 17'h10000;
  localparam logic [11:0] RAMP_RST   = 12'd60;
  // floor(x * 65536 / 100) == (x * DIM_RECIP) >> DIM_SHIFT for x <= 100
  localparam logic [21:0] DIM_RECIP  = 22'd2684355;
  localparam int          DIM_SHIFT  = 12;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_COLOR,
    OP_MAP
  } op_t;

  typedef enum logic [1:0] {
    CS_OFF   = 2'd0,
    CS_WAIT  = 2'd1,
    CS_CLOUD = 2'd2
  } cphase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_FIX,
    S_CLOUD,
    S_DIM,
    S_GOAL,
    S_DIVGO,
    S_DIVWT,
    S_STEP
  } bstate_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  hour;
    logic [31:0] epoch;
    logic [15:0] gap;
    logic [15:0] len;
    logic [6:0]  dens;
    logic [11:0] cramp;
    logic [4:0]  idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [2:0]  mode;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] phase;
  } res_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [11:0] wdata;
  } cfg_t;

endpackage

// ----- design/tcfcd_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfcd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcfcd_div import tcfcd_pkg::*; #(
  parameter int DW = 24,
  parameter int SW = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [SW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic          rem_nz
);

  localparam int CW = $clog2(DW);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] dvs_r;
  logic [SW:0]   sh;
  logic          fit;

  assign sh  = {rem_r, quo_r[DW-1]};
  assign fit = sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], fit};
      rem_r <= fit ? SW'(sh - {1'b0, dvs_r}) : sh[SW-1:0];
    end
  end

  assign busy   = busy_r;
  assign done   = busy_r && (cnt_r == CW'(DW - 1));
  assign quot   = {quo_r[DW-2:0], fit};
  assign rem_nz = fit ? (SW'(sh - {1'b0, dvs_r}) != '0) : (sh[SW-1:0] != '0);

endmodule

// ----- design/tcfcd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfcd_front
// Accepts input transactions, decodes and screens them, queues them.
// ----------------------------------------------------------------------------
module tcfcd_front import tcfcd_pkg::*; #(
  parameter int NUM_COLORS = NUM_COLORS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_hour_now,
  input  logic [31:0] in_epoch_seconds,
  input  logic [15:0] in_gap_draw,
  input  logic [15:0] in_length_draw,
  input  logic [6:0]  in_density_draw,
  input  logic [11:0] in_cloud_ramp_draw,
  input  logic [4:0]  in_entry_index,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [2:0]  in_mode_in,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  item_t         slot_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  item_t         itm;
  logic          keep;
  logic          wr, rd;

  always_comb begin
    keep      = 1'b0;
    itm.op    = OP_TICK;
    itm.hour  = (in_hour_now > HOUR_LAST) ? '0 : in_hour_now;
    itm.epoch = in_epoch_seconds;
    itm.gap   = in_gap_draw;
    itm.len   = in_length_draw;
    itm.dens  = (in_density_draw > DENS_MAX) ? DENS_MAX : in_density_draw;
    itm.cramp = in_cloud_ramp_draw;
    itm.idx   = in_entry_index;
    itm.red   = in_red_in;
    itm.green = in_green_in;
    itm.blue  = in_blue_in;
    itm.mode  = in_mode_in;
    unique case (in_command)
      CMD_TICK: begin
        keep = 1'b1;
      end
      CMD_COLOR: begin
        itm.op = OP_COLOR;
        keep   = 32'(in_entry_index) < NUM_COLORS;
      end
      CMD_MAP: begin
        itm.op = OP_MAP;
        keep   = 32'(in_entry_index) < HOURS;
      end
      default: keep = 1'b0;  // unknown command is dropped
    endcase
  end

  assign in_full = cnt_r == CW'(QDEPTH);
  assign wr      = in_push && !in_full && keep;
  assign rd      = q_pop && q_valid;
  assign q_valid = cnt_r != '0;
  assign q_item  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= PW'(wp_r + 1'b1);
      if (rd) rp_r <= PW'(rp_r + 1'b1);
      cnt_r <= CW'(cnt_r + CW'(wr) - CW'(rd));
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slot_r[wp_r] <= itm;
  end

endmodule

// ----- design/tcfcd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfcd_back
// Runs queued transactions: table writes, cloud machine, fade, result queue.
// ----------------------------------------------------------------------------
module tcfcd_back import tcfcd_pkg::*; #(
  parameter int NUM_COLORS       = NUM_COLORS_DEF,
  parameter int STEPS_PER_SECOND = SPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output res_t       out_res
);

  localparam int CIW = $clog2(NUM_COLORS);
  localparam int SW  = 12 + $clog2(STEPS_PER_SECOND + 1);
  localparam int OPW = $clog2(ODEPTH);
  localparam int OCW = $clog2(ODEPTH + 1);

  bstate_t state_r, state_nxt;
  item_t   cur_r;

  logic [11:0] ramp_r;
  logic [3:0]  foc_r;
  logic        clouds_r;

  logic [23:0]        now_r  [3];
  logic [23:0]        goal_r [3];
  logic signed [24:0] step_r [3];
  logic [4:0]         last_hour_r;
  cphase_t            cloud_r;
  logic [31:0]        dl_r;
  logic [16:0]        dim_r;
  logic [2:0]         hmap_r [HOURS];

  logic [23:0]           cmem [NUM_COLORS];
  logic [NUM_COLORS-1:0] cvalid_r;
  logic [CIW-1:0]        rd_addr;
  logic [23:0]           rd_data_r;
  logic                  rd_ok_r;

  logic          refresh_r, cramp_sel_r, start_r, sel_ok_r;
  logic [28:0]   dprod_r;
  logic [SW-1:0] steps_r;
  logic [23:0]   color_r;
  logic [1:0]    ch_r;

  res_t           of_mem_r [ODEPTH];
  logic [OPW-1:0] of_wp_r, of_rp_r;
  logic [OCW-1:0] of_cnt_r;
  logic           of_push, of_full, of_rd;

  logic        fixed_mode;
  logic [2:0]  map_sel;
  logic        hchg, late;
  logic        c_refresh, c_cramp, c_start, c_drop;
  cphase_t     c_cs;
  logic [31:0] c_dl;

  logic [23:0] dnow, dgoal, mag;
  logic        neg, trivial;
  logic        div_start, div_busy, div_done, div_rnz;
  logic [23:0] div_q;
  logic [24:0] qc;

  logic [23:0] nxt_lvl [3];
  res_t        res;

  function automatic logic [23:0] step_lvl(input logic [23:0] now,
                                           input logic [23:0] goal,
                                           input logic signed [24:0] st);
    logic signed [26:0] dif, n, d2, se;
    logic [26:0] ad, ast, ad2;
    logic [23:0] r;
    dif = $signed({3'b0, goal}) - $signed({3'b0, now});
    ad  = (dif < 0) ? 27'(-dif) : 27'(dif);
    se  = {{2{st[24]}}, st};
    ast = (se < 0) ? 27'(-se) : 27'(se);
    n   = $signed({3'b0, now}) + se;
    d2  = $signed({3'b0, goal}) - n;
    ad2 = (d2 < 0) ? 27'(-d2) : 27'(d2);
    if (now == goal)                 r = now;
    else if (st == '0 || ast >= ad)  r = goal;
    else if (ad2 > ad)               r = goal;  // step points away
    else                             r = n[23:0];
    return r;
  endfunction

  assign fixed_mode = 32'(foc_r) < NUM_COLORS;
  assign map_sel    = hmap_r[cur_r.hour];
  assign rd_addr    = (state_r == S_DEC) ? foc_r[CIW-1:0] : CIW'(map_sel);

  // cloud machine decision for the current tick
  always_comb begin
    hchg      = cur_r.hour != last_hour_r;
    late      = dl_r < cur_r.epoch;
    c_refresh = hchg;
    c_cramp   = 1'b0;
    c_start   = 1'b0;
    c_drop    = 1'b0;
    c_cs      = cloud_r;
    c_dl      = dl_r;
    unique case (cloud_r)
      CS_OFF: begin
        if (clouds_r) begin
          c_dl = cur_r.epoch + 32'(cur_r.gap);
          c_cs = CS_WAIT;
        end
      end
      CS_WAIT: begin
        if (!clouds_r) begin
          c_drop = 1'b1;
        end else if (late) begin
          c_start   = 1'b1;
          c_refresh = 1'b1;
          c_cramp   = 1'b1;
          c_dl      = cur_r.epoch + 32'(cur_r.len);
          c_cs      = CS_CLOUD;
        end
      end
      CS_CLOUD: begin
        c_cramp = 1'b1;
        if (late || !clouds_r) c_drop = 1'b1;
      end
      default: c_drop = 1'b1;
    endcase
    if (c_drop) begin
      c_refresh = 1'b1;
      c_cramp   = 1'b0;
      c_cs      = CS_OFF;
    end
  end

  always_comb begin
    dnow    = now_r[ch_r];
    dgoal   = goal_r[ch_r];
    neg     = dnow > dgoal;
    mag     = neg ? (dnow - dgoal) : (dgoal - dnow);
    trivial = (mag == '0) || (steps_r == '0);
    qc      = {1'b0, div_q} + 25'(div_rnz);
  end

  always_comb begin
    for (int c = 0; c < 3; c++) nxt_lvl[c] = step_lvl(now_r[c], goal_r[c], step_r[c]);
  end

  tcfcd_div #(.DW(24), .SW(SW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (steps_r),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q),
    .rem_nz   (div_rnz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    of_push   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && !of_full) begin
          q_pop     = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (cur_r.op == OP_TICK) state_nxt = fixed_mode ? S_FIX : S_CLOUD;
        else                     state_nxt = S_IDLE;
      end
      S_FIX: begin
        of_push   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CLOUD: state_nxt = S_DIM;
      S_DIM:   state_nxt = refresh_r ? S_GOAL : S_STEP;
      S_GOAL:  state_nxt = S_DIVGO;
      S_DIVGO: begin
        if (trivial) begin
          state_nxt = (ch_r == 2'd2) ? S_STEP : S_DIVGO;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIVWT;
        end
      end
      S_DIVWT: begin
        if (div_done) state_nxt = (ch_r == 2'd2) ? S_STEP : S_DIVGO;
      end
      S_STEP: begin
        of_push   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // color table with registered read
  always_ff @(posedge clk) begin
    if (state_r == S_DEC && cur_r.op == OP_COLOR)
      cmem[cur_r.idx[CIW-1:0]] <= {cur_r.red, cur_r.green, cur_r.blue};
    rd_data_r <= cmem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_item;
    if (state_r == S_CLOUD) begin
      refresh_r   <= c_refresh;
      cramp_sel_r <= c_cramp;
      start_r     <= c_start;
      sel_ok_r    <= 32'(map_sel) < NUM_COLORS;
      dprod_r     <= 29'(DENS_MAX - cur_r.dens) * 29'(DIM_RECIP);
    end
    if (state_r == S_DIM) begin
      color_r <= (rd_ok_r && sel_ok_r) ? rd_data_r : '0;
      steps_r <= SW'(cramp_sel_r ? cur_r.cramp : ramp_r) * SW'(STEPS_PER_SECOND);
    end
    if (state_r == S_GOAL) ch_r <= '0;
    else if ((state_r == S_DIVGO && trivial) || (state_r == S_DIVWT && div_done))
      ch_r <= 2'(ch_r + 1'b1);
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        now_r[c]  <= '0;
        goal_r[c] <= '0;
        step_r[c] <= '0;
      end
      for (int h = 0; h < HOURS; h++) hmap_r[h] <= '0;
      cvalid_r    <= '0;
      rd_ok_r     <= 1'b0;
      last_hour_r <= HOUR_NONE;
      cloud_r     <= CS_OFF;
      dl_r        <= '0;
      dim_r       <= DIM_ONE;
      ramp_r      <= RAMP_RST;
      foc_r       <= 4'(NUM_COLORS_DEF);
      clouds_r    <= 1'b0;
    end else begin
      rd_ok_r <= cvalid_r[rd_addr];
      if (state_r == S_DEC && cur_r.op == OP_COLOR) cvalid_r[cur_r.idx[CIW-1:0]] <= 1'b1;
      if (state_r == S_DEC && cur_r.op == OP_MAP)   hmap_r[cur_r.idx] <= cur_r.mode;
      if (state_r == S_FIX) begin
        for (int c = 0; c < 3; c++) begin
          now_r[c]  <= rd_ok_r ? {rd_data_r[23-8*c -: 8], 16'h0} : '0;
          goal_r[c] <= rd_ok_r ? {rd_data_r[23-8*c -: 8], 16'h0} : '0;
          step_r[c] <= '0;
        end
      end
      if (state_r == S_CLOUD) begin
        last_hour_r <= cur_r.hour;
        cloud_r     <= c_cs;
        dl_r        <= c_dl;
        if (c_drop) dim_r <= DIM_ONE;
      end
      if (state_r == S_DIM && start_r) dim_r <= dprod_r[DIM_SHIFT +: 17];
      if (state_r == S_GOAL) begin
        for (int c = 0; c < 3; c++)
          goal_r[c] <= 24'(color_r[23-8*c -: 8] * dim_r);
      end
      if (state_r == S_DIVGO && trivial) step_r[ch_r] <= '0;
      if (state_r == S_DIVWT && div_done)
        step_r[ch_r] <= neg ? -$signed(qc) : $signed(qc);
      if (state_r == S_STEP) begin
        for (int c = 0; c < 3; c++) now_r[c] <= nxt_lvl[c];
      end
      // register writes take priority and force a refresh
      if (cfg.we && cfg.index != 2'd3) begin
        unique case (cfg.index)
          REG_RAMP:   ramp_r   <= cfg.wdata;
          REG_FIXED:  foc_r    <= cfg.wdata[3:0];
          REG_CLOUDS: clouds_r <= cfg.wdata[0];
          default:    ramp_r   <= ramp_r;
        endcase
        last_hour_r <= HOUR_NONE;
        dim_r       <= DIM_ONE;
        cloud_r     <= CS_OFF;
      end
    end
  end

  // result queue
  always_comb begin
    res.phase = cloud_r;
    if (state_r == S_FIX) begin
      res.red   = rd_ok_r ? rd_data_r[23:16] : '0;
      res.green = rd_ok_r ? rd_data_r[15:8]  : '0;
      res.blue  = rd_ok_r ? rd_data_r[7:0]   : '0;
    end else begin
      res.red   = nxt_lvl[0][23:16];
      res.green = nxt_lvl[1][23:16];
      res.blue  = nxt_lvl[2][23:16];
    end
  end

  assign of_full   = of_cnt_r == OCW'(ODEPTH);
  assign out_empty = of_cnt_r == '0;
  assign of_rd     = out_pop && !out_empty;
  assign out_res   = of_mem_r[of_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wp_r  <= '0;
      of_rp_r  <= '0;
      of_cnt_r <= '0;
    end else begin
      if (of_push) of_wp_r <= OPW'(of_wp_r + 1'b1);
      if (of_rd)   of_rp_r <= OPW'(of_rp_r + 1'b1);
      of_cnt_r <= OCW'(of_cnt_r + OCW'(of_push) - OCW'(of_rd));
    end
  end

  always_ff @(posedge clk) begin
    if (of_push) of_mem_r[of_wp_r] <= res;
  end

`ifndef SYNTH
  a_of_bound: assert property (@(posedge clk) disable iff (!rst_n)
    of_cnt_r <= OCW'(ODEPTH)) else $error("result queue overflow");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIVWT |-> div_busy) else $error("waiting on idle divider");

  a_cfg_off: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.we && (cfg.index == REG_RAMP || cfg.index == REG_FIXED ||
               cfg.index == REG_CLOUDS) |=> cloud_r == CS_OFF && dim_r == DIM_ONE)
    else $error("register write did not reset cloud machine");
`endif

endmodule

// ----- design/timed_color_fade_cloud_dimmer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_color_fade_cloud_dimmer_top
// RGB fade engine with hourly color cycling and random cloud dimming.
// ----------------------------------------------------------------------------
// Push one transaction per 20 ms tick (command 0) and get one result back with
// the integer red, green and blue levels and the cloud phase; color table and
// hour map writes (commands 1 and 2) give no result, and command 3 or a write
// with an out-of-range index is dropped at the front. The front screens items
// into a two-entry queue, so full only rises when the back falls behind. The
// back handles one transaction at a time: a table write passes only through
// decode, a fixed-color tick through decode and fixed output, a cycle-mode
// tick through decode, cloud, dim and step, and a goal-setting tick also
// through the goal state and the shared 24-bit serial divider, which computes
// the three per-channel fade steps in turn. Results wait in a two-entry output
// queue. Register writes go through the cfg port, to be made only while the
// block is idle (not enforced by the block); each one returns the cloud machine
// to off, restores full brightness and forces a goal refresh on the next tick.
// ----------------------------------------------------------------------------
module timed_color_fade_cloud_dimmer_top import tcfcd_pkg::*; #(
  parameter int NUM_COLORS       = NUM_COLORS_DEF,
  parameter int STEPS_PER_SECOND = SPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_hour_now,
  input  logic [31:0] in_epoch_seconds,
  input  logic [15:0] in_gap_draw,
  input  logic [15:0] in_length_draw,
  input  logic [6:0]  in_density_draw,
  input  logic [11:0] in_cloud_ramp_draw,
  input  logic [4:0]  in_entry_index,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [2:0]  in_mode_in,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [1:0]  out_cloud_phase
);

  logic  q_valid, q_pop;
  item_t q_item;
  cfg_t  cfg;
  res_t  res;

  assign cfg = '{we: cfg_we, index: cfg_index, wdata: cfg_wdata};

  tcfcd_front #(.NUM_COLORS(NUM_COLORS)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_command         (in_command),
    .in_hour_now        (in_hour_now),
    .in_epoch_seconds   (in_epoch_seconds),
    .in_gap_draw        (in_gap_draw),
    .in_length_draw     (in_length_draw),
    .in_density_draw    (in_density_draw),
    .in_cloud_ramp_draw (in_cloud_ramp_draw),
    .in_entry_index     (in_entry_index),
    .in_red_in          (in_red_in),
    .in_green_in        (in_green_in),
    .in_blue_in         (in_blue_in),
    .in_mode_in         (in_mode_in),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop)
  );

  tcfcd_back #(
    .NUM_COLORS       (NUM_COLORS),
    .STEPS_PER_SECOND (STEPS_PER_SECOND)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  assign out_red_out     = res.red;
  assign out_green_out   = res.green;
  assign out_blue_out    = res.blue;
  assign out_cloud_phase = res.phase;

endmodule

// ----- test/timed_color_fade_cloud_dimmer_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_color_fade_cloud_dimmer_top_tb
// Self-checking bench for the timed color fade engine.
// ----------------------------------------------------------------------------
// An initial block fills a queue of pending transactions in phases, each phase
// under one register setting. A clocked driver pushes them at the falling edge
// with random gaps. Every accepted tick is run through an in-bench fade model,
// and the expected levels and cloud phase are queued. A clocked monitor pops
// results with random stalls and compares each one with the oldest expected
// result.
// ----------------------------------------------------------------------------
module timed_color_fade_cloud_dimmer_top_tb;
  import tcfcd_pkg::*;

  localparam int NCOL = NUM_COLORS_DEF;
  localparam int SPS  = SPS_DEF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_RAMP;
  logic [11:0] cfg_wdata = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  item_t       drv = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_red_out, out_green_out, out_blue_out;
  logic [1:0]  out_cloud_phase;

  timed_color_fade_cloud_dimmer_top i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_push, .in_full,
    .in_command(drv.op), .in_hour_now(drv.hour), .in_epoch_seconds(drv.epoch),
    .in_gap_draw(drv.gap), .in_length_draw(drv.len), .in_density_draw(drv.dens),
    .in_cloud_ramp_draw(drv.cramp), .in_entry_index(drv.idx),
    .in_red_in(drv.red), .in_green_in(drv.green), .in_blue_in(drv.blue),
    .in_mode_in(drv.mode),
    .out_empty, .out_pop, .out_red_out, .out_green_out, .out_blue_out,
    .out_cloud_phase
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- fade model
  logic [23:0] lvl_now [3];
  logic [23:0] lvl_goal[3];
  longint      lvl_step[3];
  logic [4:0]  prev_hour;
  cphase_t     cphase;
  logic [31:0] cloud_end;
  logic [16:0] dim;
  logic [7:0]  ctab[NCOL][3];
  logic [2:0]  hmap[HOURS];
  logic [11:0] r_ramp;
  logic [3:0]  r_fixed;
  logic        r_clouds;

  res_t   fade_expected[$];
  item_t  pending_items[$];
  int     mismatches = 0;
  bit     hold_rx = 1'b0;   // long receiver hold-off
  bit     rx_free = 1'b0;   // stretch with no receiver stalls
  bit     tx_free = 1'b0;   // stretch with no sender gaps

  function automatic longint fade_step(logic [23:0] goal, logic [23:0] now,
                                       logic [11:0] ramp);
    longint diff, steps, q;
    diff  = longint'(goal) - longint'(now);
    steps = longint'(ramp) * SPS;
    if (diff == 0 || steps == 0) return 0;
    q = ((diff < 0 ? -diff : diff) + steps - 1) / steps;
    return diff < 0 ? -q : q;
  endfunction

  function automatic void aim_goal(logic [4:0] hr, logic [11:0] ramp);
    logic [2:0] sel;
    longint     b;
    sel = hmap[hr];
    for (int c = 0; c < 3; c++) begin
      b = (sel < NCOL) ? ctab[sel][c] : 0;
      lvl_goal[c] = 24'(b * dim);
      lvl_step[c] = fade_step(lvl_goal[c], lvl_now[c], ramp);
    end
  endfunction

  function automatic void hour_check(logic [4:0] hr, logic [11:0] ramp);
    if (hr != prev_hour) begin
      prev_hour = hr;
      aim_goal(hr, ramp);
    end
  endfunction

  function automatic void cloud_off(logic [4:0] hr);
    prev_hour = HOUR_NONE;
    dim = DIM_ONE;
    hour_check(hr, r_ramp);
    cphase = CS_OFF;
  endfunction

  function automatic logic [23:0] move_level(logic [23:0] now, logic [23:0] goal,
                                             longint st);
    longint d, d2, n;
    if (now == goal) return now;
    d = longint'(goal) - longint'(now);
    if (d < 0) d = -d;
    if (st == 0 || (st < 0 ? -st : st) >= d) return goal;
    n = longint'(now) + st;
    d2 = longint'(goal) - n;
    if (d2 < 0) d2 = -d2;
    if (d2 > d) return goal;
    return n[23:0];
  endfunction

  function automatic void fade_reset();
    for (int c = 0; c < 3; c++) begin
      lvl_now[c] = '0; lvl_goal[c] = '0; lvl_step[c] = 0;
    end
    for (int i = 0; i < NCOL; i++) for (int c = 0; c < 3; c++) ctab[i][c] = '0;
    for (int i = 0; i < HOURS; i++) hmap[i] = '0;
    prev_hour = HOUR_NONE; cphase = CS_OFF; cloud_end = '0; dim = DIM_ONE;
    r_ramp = RAMP_RST; r_fixed = 4'(NCOL); r_clouds = 1'b0;
  endfunction

  function automatic void fade_cfg(logic [1:0] idx, logic [11:0] val);
    case (idx)
      REG_RAMP:   r_ramp = val;
      REG_FIXED:  r_fixed = val[3:0];
      REG_CLOUDS: r_clouds = val[0];
      default:    return;
    endcase
    prev_hour = HOUR_NONE; dim = DIM_ONE; cphase = CS_OFF;
  endfunction

  // Applies one accepted transaction; ticks queue an expected result.
  function automatic void fade_apply(item_t it);
    logic [4:0] hr;
    logic [6:0] dn;
    res_t       r;
    if (it.op == OP_COLOR) begin
      if (it.idx < NCOL) begin
        ctab[it.idx][0] = it.red; ctab[it.idx][1] = it.green; ctab[it.idx][2] = it.blue;
      end
      return;
    end
    if (it.op == OP_MAP) begin
      if (it.idx < HOURS) hmap[it.idx] = it.mode;
      return;
    end
    if (it.op != OP_TICK) return;
    hr = (it.hour > HOUR_LAST) ? 5'd0 : it.hour;
    if (r_fixed < NCOL) begin
      for (int c = 0; c < 3; c++) begin
        lvl_now[c] = {ctab[r_fixed][c], 16'h0};
        lvl_goal[c] = lvl_now[c];
        lvl_step[c] = 0;
      end
    end else begin
      case (cphase)
        CS_OFF: begin
          hour_check(hr, r_ramp);
          if (r_clouds) begin
            cloud_end = it.epoch + 32'(it.gap);
            cphase = CS_WAIT;
          end
        end
        CS_WAIT: begin
          hour_check(hr, r_ramp);
          if (!r_clouds) cloud_off(hr);
          else if (cloud_end < it.epoch) begin
            dn = (it.dens > DENS_MAX) ? DENS_MAX : it.dens;
            cloud_end = it.epoch + 32'(it.len);
            dim = 17'(((100 - int'(dn)) * 65536) / 100);
            prev_hour = HOUR_NONE;
            hour_check(hr, it.cramp);
            cphase = CS_CLOUD;
          end
        end
        default: begin
          hour_check(hr, it.cramp);
          if (cloud_end < it.epoch || !r_clouds) cloud_off(hr);
        end
      endcase
      for (int c = 0; c < 3; c++)
        lvl_now[c] = move_level(lvl_now[c], lvl_goal[c], lvl_step[c]);
    end
    r.red = lvl_now[0][23:16]; r.green = lvl_now[1][23:16];
    r.blue = lvl_now[2][23:16]; r.phase = cphase;
    fade_expected.push_back(r);
  endfunction

  // ------------------------------------------------------------------- driver
  always @(negedge clk) begin
    if (pending_items.size() != 0 && (tx_free || $urandom_range(99) >= 21)) begin
      in_push <= 1'b1;
      drv <= pending_items[0];
    end else begin
      in_push <= 1'b0;
      drv <= item_t'($urandom);
    end
  end

  // Acceptance is judged at the rising edge; the model and the pending queue
  // advance there so expectations stay ahead of results.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      fade_apply(drv);
      void'(pending_items.pop_front());
    end
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_pop && !out_empty) begin
      got = '{out_red_out, out_green_out, out_blue_out, out_cloud_phase};
      if (fade_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = fade_expected.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_pop <= !hold_rx && (rx_free || $urandom_range(99) >= 21);
  end

  // ---------------------------------------------------------------- stimulus
  logic [31:0] wall;

  function automatic item_t rnd_tick(bit near);
    item_t it;
    it = item_t'({$urandom, $urandom, $urandom, $urandom});
    it.op = OP_TICK;
    if (near) begin
      it.hour  = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(23));
      wall     = wall + $urandom_range(3);
      it.epoch = wall;
      it.gap   = 16'($urandom_range(6));
      it.len   = 16'($urandom_range(6));
      it.dens  = ($urandom_range(7) == 0) ? 7'($urandom) : 7'($urandom_range(100));
      it.cramp = 12'($urandom_range(3));
    end
    return it;
  endfunction

  function automatic item_t rnd_write();
    item_t it;
    it = item_t'({$urandom, $urandom, $urandom, $urandom});
    it.op = $urandom_range(1) ? OP_COLOR : OP_MAP;
    if ($urandom_range(7) != 0) it.idx = 5'($urandom_range(23));
    return it;
  endfunction

  task automatic drain();
    wait (pending_items.size() == 0 && !in_push);
    wait (fade_expected.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk) fade_cfg(idx, val);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int n, logic [11:0] ramp, logic [3:0] fx, logic c);
    item_t it;
    drain();
    set_reg(REG_RAMP, ramp);
    set_reg(REG_FIXED, fx);
    set_reg(REG_CLOUDS, {11'd0, c});
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 2) pending_items.push_back(rnd_write());
      else pending_items.push_back(rnd_tick($urandom_range(19) != 0));
    end
  endtask

  initial begin
    item_t it;
    fade_reset();
    wall = 32'd1000;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: table and map extremes, bad indexes, command 3, hour wrap.
    for (int i = 0; i < 4; i++) begin
      it = '0; it.op = OP_COLOR; it.idx = 5'(i);
      it.red = (i == 0) ? 8'hFF : 8'($urandom); it.green = (i == 1) ? 8'hFF : 8'h00;
      it.blue = (i == 2) ? 8'hFF : 8'h80;
      pending_items.push_back(it);
    end
    it = '0; it.op = OP_COLOR; it.idx = 5'd31; it.red = 8'hFF; pending_items.push_back(it);
    it = '0; it.op = OP_MAP; it.idx = 5'd23; it.mode = 3'd7; pending_items.push_back(it);
    it = '0; it.op = OP_MAP; it.idx = 5'd5; it.mode = 3'd1; pending_items.push_back(it);
    it = '0; it.op = OP_MAP; it.idx = 5'd24; it.mode = 3'd2; pending_items.push_back(it);
    it = '0; it.op = op_t'(2'd3); pending_items.push_back(it);
    for (int h = 0; h < 6; h++) begin
      it = rnd_tick(1'b1);
      it.hour = (h == 0) ? 5'd31 : (h == 1) ? 5'd23 : (h == 2) ? 5'd5 : 5'd0;
      it.epoch = (h == 5) ? 32'hFFFF_FFFF : it.epoch;
      pending_items.push_back(it);
    end
    drain();
    set_reg(REG_RAMP, 12'd0);
    for (int i = 0; i < 4; i++) begin
      it = rnd_tick(1'b1); it.hour = 5'(i * 5); pending_items.push_back(it);
    end

    // Receiver holds off while the sender keeps pushing, so the block fills.
    run_phase(30, 12'd1, 4'd8, 1'b1);
    hold_rx = 1'b1;
    repeat (400) @(posedge clk);
    hold_rx = 1'b0;

    // Random phases over several register settings.
    run_phase(200, 12'd1,    4'd8,  1'b1);
    tx_free = 1'b1; rx_free = 1'b1;
    run_phase(150, 12'd0,    4'd15, 1'b1);
    tx_free = 1'b0; rx_free = 1'b0;
    run_phase(60,  12'd4095, 4'd8,  1'b1);
    run_phase(60,  12'd2,    4'd0,  1'b0);
    run_phase(60,  12'd3,    4'd7,  1'b1);
    run_phase(200, 12'd2,    4'd9,  1'b0);
    run_phase(300, 12'd1,    4'd8,  1'b1);
    run_phase(60,  12'd5,    4'd8,  1'b0);
    drain();

    if (mismatches == 0) $display("[timed_color_fade_cloud_dimmer_top] OK");
    else $display("[timed_color_fade_cloud_dimmer_top] ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("[timed_color_fade_cloud_dimmer_top] ERROR");
    $finish;
  end

endmodule
